@@ sv/gsf_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the
// grid shape fill block. No dependencies.
package gsf_pkg;

    // Grid geometry: x runs over rows, y over columns
    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int DEPTH     = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);

    // Word field widths
    localparam int REQ_W  = 2;
    localparam int POS_W  = 8;
    localparam int SIZE_W = 7;
    localparam int RAD_W  = 6;
    localparam int TYPE_W = 2;

    // Internal coordinate width: covers corner plus extent and center plus
    // or minus radius, signed
    localparam int CRD_W  = 10;
    // Square root: operand, rounded result and partial remainder widths
    localparam int SQ_W   = 2 * RAD_W;
    localparam int H_W    = RAD_W + 1;
    localparam int REM_W  = RAD_W + 3;
    localparam int STEP_W = $clog2(RAD_W + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_POINT  = 2'd0,
        REQ_RECT   = 2'd1,
        REQ_CIRCLE = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    // Source of a span walk: the rectangle, or the upper/lower circle row
    typedef enum logic [1:0] {
        WSEL_RECT = 2'd0,
        WSEL_UP   = 2'd1,
        WSEL_DN   = 2'd2
    } t_wsel;

    typedef struct packed {
        logic  accept;
        logic  walk_load;
        t_wsel wsel;
        logic  walk_step;
        logic  sqrt_start;
        logic  next_row;
        logic  clr_step;
        logic  rd_issue;
        logic  rd_take;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic shape_empty;
        logic walk_last;
        logic sqrt_done;
        logic row_last;
        logic clr_last;
    } t_stat;

endpackage

@@ sv/gsf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsf_ram #(
    parameter  int WIDTH = 2,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/gsf_isqrt.sv @@
// Bit-serial integer square root with round-to-nearest, one result bit
// per cycle. Depends on gsf_pkg.
module gsf_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [gsf_pkg::SQ_W-1:0] i_n,
    output logic                     o_done,
    output logic [gsf_pkg::H_W-1:0]  o_h
);

    logic                        r_busy;
    logic [gsf_pkg::STEP_W-1:0]  r_cnt;
    logic [gsf_pkg::SQ_W-1:0]    r_n;
    logic [gsf_pkg::REM_W-1:0]   r_rem;
    logic [gsf_pkg::RAD_W-1:0]   r_root;

    logic [gsf_pkg::REM_W-1:0]   rem_sh;
    logic [gsf_pkg::REM_W-1:0]   trial;
    logic                        fits;

    // Bring down the next two operand bits and try root*4+1
    assign rem_sh = {r_rem[gsf_pkg::REM_W-3:0], r_n[gsf_pkg::SQ_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= gsf_pkg::STEP_W'(gsf_pkg::RAD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == gsf_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[gsf_pkg::SQ_W-3:0], 2'b00};
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[gsf_pkg::RAD_W-2:0], fits};
        end
    end

    // Round up when n - s*s exceeds s
    assign o_done = !r_busy;
    assign o_h    = (r_rem > gsf_pkg::REM_W'(r_root))
                  ? gsf_pkg::H_W'(r_root) + 1'b1
                  : gsf_pkg::H_W'(r_root);

endmodule

@@ sv/gsf_datapath.sv @@
// Datapath: command word latch, span walker, circle row stepping, clear
// sweep, grid addressing and result register. Depends on gsf_pkg, gsf_isqrt.
module gsf_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gsf_pkg::t_cmd                i_cmd,
    output gsf_pkg::t_stat               o_stat,
    input  logic [gsf_pkg::REQ_W-1:0]    i_req_type,
    input  logic signed [gsf_pkg::POS_W-1:0] i_x_pos,
    input  logic signed [gsf_pkg::POS_W-1:0] i_y_pos,
    input  logic [gsf_pkg::SIZE_W-1:0]   i_x_size,
    input  logic [gsf_pkg::SIZE_W-1:0]   i_y_size,
    input  logic [gsf_pkg::RAD_W-1:0]    i_radius,
    input  logic [gsf_pkg::TYPE_W-1:0]   i_cell_type,
    output logic                         o_we,
    output logic [gsf_pkg::ADDR_W-1:0]   o_waddr,
    output logic [gsf_pkg::TYPE_W-1:0]   o_wdata,
    output logic                         o_re,
    output logic [gsf_pkg::ADDR_W-1:0]   o_raddr,
    input  logic [gsf_pkg::TYPE_W-1:0]   i_rdata,
    output logic [gsf_pkg::TYPE_W-1:0]   o_read_value
);

    localparam logic signed [gsf_pkg::CRD_W-1:0] CrdRows = gsf_pkg::CRD_W'(gsf_pkg::GRID_ROWS);
    localparam logic signed [gsf_pkg::CRD_W-1:0] CrdCols = gsf_pkg::CRD_W'(gsf_pkg::GRID_COLS);
    localparam int PadP = gsf_pkg::CRD_W - gsf_pkg::POS_W;
    localparam int PadR = gsf_pkg::CRD_W - gsf_pkg::RAD_W;
    localparam int PadH = gsf_pkg::CRD_W - gsf_pkg::H_W;

    function automatic logic in_grid(input logic signed [gsf_pkg::CRD_W-1:0] x,
                                     input logic signed [gsf_pkg::CRD_W-1:0] y);
        return !x[gsf_pkg::CRD_W-1] && !y[gsf_pkg::CRD_W-1] && (x < CrdRows) && (y < CrdCols);
    endfunction

    function automatic logic [gsf_pkg::ADDR_W-1:0] cell_addr(
        input logic signed [gsf_pkg::CRD_W-1:0] x,
        input logic signed [gsf_pkg::CRD_W-1:0] y);
        logic [gsf_pkg::ADDR_W-1:0] xa;
        logic [gsf_pkg::ADDR_W-1:0] ya;
        xa = gsf_pkg::ADDR_W'(x[gsf_pkg::ROW_W-1:0]);
        ya = gsf_pkg::ADDR_W'(y[gsf_pkg::COL_W-1:0]);
        return gsf_pkg::ADDR_W'(xa * gsf_pkg::ADDR_W'(gsf_pkg::GRID_COLS) + ya);
    endfunction

    // Latched command word
    gsf_pkg::t_req                   r_req;
    logic signed [gsf_pkg::POS_W-1:0] r_x_pos;
    logic signed [gsf_pkg::POS_W-1:0] r_y_pos;
    logic [gsf_pkg::SIZE_W-1:0]      r_x_size;
    logic [gsf_pkg::SIZE_W-1:0]      r_y_size;
    logic [gsf_pkg::RAD_W-1:0]       r_radius;
    logic [gsf_pkg::TYPE_W-1:0]      r_cell_type;
    logic [gsf_pkg::SQ_W-1:0]        r_rr;
    logic [gsf_pkg::RAD_W-1:0]       r_d;

    // Span walker
    logic signed [gsf_pkg::CRD_W-1:0] r_wx;
    logic signed [gsf_pkg::CRD_W-1:0] r_wy;
    logic signed [gsf_pkg::CRD_W-1:0] r_wy0;
    logic [gsf_pkg::SIZE_W-1:0]      r_rem_x;
    logic [gsf_pkg::SIZE_W-1:0]      r_rem_y;
    logic [gsf_pkg::SIZE_W-1:0]      r_ys;

    logic [gsf_pkg::ADDR_W-1:0]      r_clr;
    logic [gsf_pkg::TYPE_W-1:0]      r_rd_val;
    logic [gsf_pkg::TYPE_W-1:0]      r_out;

    logic signed [gsf_pkg::CRD_W-1:0] xc;
    logic signed [gsf_pkg::CRD_W-1:0] yc;
    logic signed [gsf_pkg::CRD_W-1:0] dd;
    logic signed [gsf_pkg::CRD_W-1:0] hh;
    logic signed [gsf_pkg::CRD_W-1:0] ld_x0;
    logic signed [gsf_pkg::CRD_W-1:0] ld_y0;
    logic [gsf_pkg::SIZE_W-1:0]      ld_xs;
    logic [gsf_pkg::SIZE_W-1:0]      ld_ys;
    logic [gsf_pkg::SIZE_W-1:0]      rect_xs;
    logic [gsf_pkg::SIZE_W-1:0]      rect_ys;
    logic [gsf_pkg::SQ_W-1:0]        sq_n;
    logic                            sq_done;
    logic [gsf_pkg::H_W-1:0]         sq_h;
    logic                            rd_in_grid;
    logic                            shape_empty;

    assign xc = {{PadP{r_x_pos[gsf_pkg::POS_W-1]}}, r_x_pos};
    assign yc = {{PadP{r_y_pos[gsf_pkg::POS_W-1]}}, r_y_pos};
    assign dd = {{PadR{1'b0}}, r_d};
    assign hh = {{PadH{1'b0}}, sq_h};

    // A point is a one-cell rectangle
    assign rect_xs = (r_req == gsf_pkg::REQ_POINT) ? gsf_pkg::SIZE_W'(1) : r_x_size;
    assign rect_ys = (r_req == gsf_pkg::REQ_POINT) ? gsf_pkg::SIZE_W'(1) : r_y_size;

    // Remaining half-width squared for the current row offset
    assign sq_n = gsf_pkg::SQ_W'(r_rr - gsf_pkg::SQ_W'(r_d) * gsf_pkg::SQ_W'(r_d));

    gsf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_n     (sq_n),
        .o_done  (sq_done),
        .o_h     (sq_h)
    );

    always_comb begin
        ld_x0 = xc;
        ld_y0 = yc;
        ld_xs = rect_xs;
        ld_ys = rect_ys;
        case (i_cmd.wsel)
            gsf_pkg::WSEL_UP: begin
                ld_x0 = xc - hh;
                ld_y0 = yc + dd;
                ld_xs = gsf_pkg::SIZE_W'({sq_h, 1'b0});
                ld_ys = gsf_pkg::SIZE_W'(1);
            end
            gsf_pkg::WSEL_DN: begin
                ld_x0 = xc - hh;
                ld_y0 = yc - dd - gsf_pkg::CRD_W'(1);
                ld_xs = gsf_pkg::SIZE_W'({sq_h, 1'b0});
                ld_ys = gsf_pkg::SIZE_W'(1);
            end
            default: begin
                ld_x0 = xc;
                ld_y0 = yc;
                ld_xs = rect_xs;
                ld_ys = rect_ys;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req       <= gsf_pkg::t_req'(i_req_type);
            r_x_pos     <= i_x_pos;
            r_y_pos     <= i_y_pos;
            r_x_size    <= i_x_size;
            r_y_size    <= i_y_size;
            r_radius    <= i_radius;
            r_cell_type <= i_cell_type;
            r_rr        <= gsf_pkg::SQ_W'(i_radius) * gsf_pkg::SQ_W'(i_radius);
            r_d         <= '0;
        end else if (i_cmd.next_row) begin
            r_d <= r_d + 1'b1;
        end

        // Walk y inside x; a load overrides the step of the last cell
        if (i_cmd.walk_load) begin
            r_wx    <= ld_x0;
            r_wy    <= ld_y0;
            r_wy0   <= ld_y0;
            r_rem_x <= ld_xs;
            r_rem_y <= ld_ys;
            r_ys    <= ld_ys;
        end else if (i_cmd.walk_step) begin
            if (r_rem_y > gsf_pkg::SIZE_W'(1)) begin
                r_wy    <= r_wy + gsf_pkg::CRD_W'(1);
                r_rem_y <= r_rem_y - 1'b1;
            end else begin
                r_wy    <= r_wy0;
                r_rem_y <= r_ys;
                r_wx    <= r_wx + gsf_pkg::CRD_W'(1);
                r_rem_x <= r_rem_x - 1'b1;
            end
        end

        if (i_cmd.rd_take) begin
            r_rd_val <= rd_in_grid ? i_rdata : '0;
        end
        if (i_cmd.out_load) begin
            r_out <= (r_req == gsf_pkg::REQ_READ) ? r_rd_val : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign rd_in_grid = in_grid(xc, yc);

    assign o_we    = i_cmd.clr_step || (i_cmd.walk_step && in_grid(r_wx, r_wy));
    assign o_waddr = i_cmd.clr_step ? r_clr : cell_addr(r_wx, r_wy);
    assign o_wdata = i_cmd.clr_step ? '0 : r_cell_type;
    assign o_re    = i_cmd.rd_issue;
    assign o_raddr = cell_addr(xc, yc);

    always_comb begin
        case (r_req)
            gsf_pkg::REQ_RECT:   shape_empty = (r_x_size == '0) || (r_y_size == '0);
            gsf_pkg::REQ_CIRCLE: shape_empty = (r_radius == '0);
            default:             shape_empty = 1'b0;
        endcase
    end

    assign o_stat.req         = r_req;
    assign o_stat.shape_empty = shape_empty;
    assign o_stat.walk_last   = (r_rem_x == gsf_pkg::SIZE_W'(1)) && (r_rem_y == gsf_pkg::SIZE_W'(1));
    assign o_stat.sqrt_done   = sq_done;
    assign o_stat.row_last    = (r_d == gsf_pkg::RAD_W'(r_radius - 1'b1));
    assign o_stat.clr_last    = (r_clr == gsf_pkg::ADDR_W'(gsf_pkg::DEPTH - 1));

    assign o_read_value = r_out;

endmodule

@@ sv/gsf_ctrl.sv @@
// Controller state machine: clear sweep, command dispatch, shape walks,
// circle rows and result handoff. Depends on gsf_pkg.
module gsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  gsf_pkg::t_stat i_stat,
    output gsf_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LAUNCH,
        ST_WALK,
        ST_ROOT,
        ST_UP,
        ST_DN,
        ST_NEXT,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    logic   out_free;

    assign out_free = !r_valid || i_ready;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        o_cmd.wsel = gsf_pkg::WSEL_RECT;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                case (i_stat.req)
                    gsf_pkg::REQ_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = ST_RD_WAIT;
                    end
                    gsf_pkg::REQ_CIRCLE: begin
                        if (i_stat.shape_empty) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.sqrt_start = 1'b1;
                            n_state          = ST_ROOT;
                        end
                    end
                    default: begin
                        if (i_stat.shape_empty) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.walk_load = 1'b1;
                            n_state         = ST_WALK;
                        end
                    end
                endcase
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_ROOT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.walk_load = 1'b1;
                    o_cmd.wsel      = gsf_pkg::WSEL_UP;
                    n_state         = ST_UP;
                end
            end
            ST_UP: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.walk_load = 1'b1;
                    o_cmd.wsel      = gsf_pkg::WSEL_DN;
                    n_state         = ST_DN;
                end
            end
            ST_DN: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    if (i_stat.row_last) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.next_row = 1'b1;
                        n_state        = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = ST_ROOT;
            end
            ST_RD_WAIT: begin
                o_cmd.rd_take = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_valid;

endmodule

@@ sv/grid_shape_fill.sv @@
// Top level of the grid shape fill block: occupancy grid of 2-bit cell types
// with point, rectangle, circle and read commands.
// Depends on gsf_pkg, gsf_ram, gsf_isqrt, gsf_datapath, gsf_ctrl.
//
//   channel | handshake          | word
//   --------+--------------------+----------------------------------------------
//   command | i_valid / o_ready  | i_req_type i_x_pos i_y_pos i_x_size i_y_size
//           |                    | i_radius i_cell_type
//   result  | o_valid / i_ready  | o_read_value
//
// Command words are taken one at a time. A rectangle walks x_size*y_size
// cells, one per cycle over the single grid RAM write port, off-grid cells
// included; each circle row takes a bit-serial root, then two spans of 2*h
// cells.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to
// all GRID_ROWS*GRID_COLS cells with o_ready held low.
// Stalls: a finished result waits in the output register while the next
// command word is accepted and worked on; only the handoff of its own result
// waits for i_ready.
module grid_shape_fill (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [gsf_pkg::REQ_W-1:0]            i_req_type,
    input  logic signed [gsf_pkg::POS_W-1:0]     i_x_pos,
    input  logic signed [gsf_pkg::POS_W-1:0]     i_y_pos,
    input  logic [gsf_pkg::SIZE_W-1:0]           i_x_size,
    input  logic [gsf_pkg::SIZE_W-1:0]           i_y_size,
    input  logic [gsf_pkg::RAD_W-1:0]            i_radius,
    input  logic [gsf_pkg::TYPE_W-1:0]           i_cell_type,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [gsf_pkg::TYPE_W-1:0]           o_read_value
);

    gsf_pkg::t_cmd               cmd;
    gsf_pkg::t_stat              stat;
    logic                        ram_we;
    logic [gsf_pkg::ADDR_W-1:0]  ram_waddr;
    logic [gsf_pkg::TYPE_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [gsf_pkg::ADDR_W-1:0]  ram_raddr;
    logic [gsf_pkg::TYPE_W-1:0]  ram_rdata;

    // Sequence the work: clear sweep, dispatch, walks and result handoff
    gsf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold the command word, walk spans, step circle rows, drive the grid
    gsf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_x_size     (i_x_size),
        .i_y_size     (i_y_size),
        .i_radius     (i_radius),
        .i_cell_type  (i_cell_type),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_wdata      (ram_wdata),
        .o_re         (ram_re),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_read_value (o_read_value)
    );

    // Grid storage, x-major: address = x*GRID_COLS + y
    gsf_ram #(
        .WIDTH (gsf_pkg::TYPE_W),
        .DEPTH (gsf_pkg::DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

@@ tb/tb_grid_shape_fill.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for grid_shape_fill: directed table, then random
// command words in bursts, checked against a cycle-free model of the grid.
// Depends on gsf_pkg and the grid_shape_fill RTL.
module tb_grid_shape_fill;

    // One command word plus, for directed rows, an optional read value typed in by hand
    typedef struct packed {
        gsf_pkg::t_req                      op;
        logic signed [gsf_pkg::POS_W-1:0]   x;
        logic signed [gsf_pkg::POS_W-1:0]   y;
        logic [gsf_pkg::SIZE_W-1:0]         xs;
        logic [gsf_pkg::SIZE_W-1:0]         ys;
        logic [gsf_pkg::RAD_W-1:0]          rad;
        logic [gsf_pkg::TYPE_W-1:0]         ctype;
        logic                               fixed;
        logic [gsf_pkg::TYPE_W-1:0]         fixed_val;
    } t_grid_word;

    localparam int N_RANDOM  = 1250;
    localparam int N_DIRECT  = 26;
    localparam int HOLD_AT   = 200;   // results seen before the long receiver hold
    localparam int HOLD_LEN  = 600;   // cycles of that hold
    localparam int DRAIN_PAD = 64;    // cycles after the last result

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic [gsf_pkg::REQ_W-1:0]         i_req_type;
    logic signed [gsf_pkg::POS_W-1:0]  i_x_pos;
    logic signed [gsf_pkg::POS_W-1:0]  i_y_pos;
    logic [gsf_pkg::SIZE_W-1:0]        i_x_size;
    logic [gsf_pkg::SIZE_W-1:0]        i_y_size;
    logic [gsf_pkg::RAD_W-1:0]         i_radius;
    logic [gsf_pkg::TYPE_W-1:0]        i_cell_type;
    logic                              o_valid;
    logic                              i_ready;
    logic [gsf_pkg::TYPE_W-1:0]        o_read_value;

    // Model of the occupancy grid, indexed [x][y]
    logic [gsf_pkg::TYPE_W-1:0] occ_map [gsf_pkg::GRID_ROWS][gsf_pkg::GRID_COLS];
    // Read values owed by the block, oldest first
    logic [gsf_pkg::TYPE_W-1:0] read_value_q [$];
    int bad_words = 0;
    int words_out = 0;

    // Directed rows: reset state, grid corners, off-grid coordinates, zero
    // sizes, the largest rectangle and circle, shapes hanging off the grid
    t_grid_word dir_tab [N_DIRECT] = '{
        '{gsf_pkg::REQ_READ,      0,    0,   0,   0,  0, 0, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,     63,   63,   0,   0,  0, 0, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,   -128, -128, 127, 127, 63, 3, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,    127,  127,   0,   0,  0, 0, 1'b1, 2'd0},
        '{gsf_pkg::REQ_POINT,     0,    0,   0,   0,  0, 3, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,      0,    0,   0,   0,  0, 0, 1'b1, 2'd3},
        '{gsf_pkg::REQ_POINT,    63,   63,   0,   0,  0, 2, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,     63,   63,   0,   0,  0, 0, 1'b1, 2'd2},
        '{gsf_pkg::REQ_POINT,     0,   64,   0,   0,  0, 1, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,      0,   63,   0,   0,  0, 0, 1'b1, 2'd0},
        '{gsf_pkg::REQ_POINT,     0,    0,   0,   0,  0, 0, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,      0,    0,   0,   0,  0, 0, 1'b1, 2'd0},
        '{gsf_pkg::REQ_RECT,      5,    5,   0,   9,  0, 2, 1'b1, 2'd0},
        '{gsf_pkg::REQ_RECT,      5,    5,   9,   0,  0, 2, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,      5,    5,   0,   0,  0, 0, 1'b1, 2'd0},
        '{gsf_pkg::REQ_RECT,   -128, -128, 127, 127,  0, 1, 1'b1, 2'd0},
        '{gsf_pkg::REQ_RECT,     60,   -2, 127, 127,  0, 1, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,     63,   63,   0,   0,  0, 0, 1'b0, 2'd0},
        '{gsf_pkg::REQ_RECT,     -1,   -1,   3,   3,  0, 2, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,      0,    0,   0,   0,  0, 0, 1'b0, 2'd0},
        '{gsf_pkg::REQ_CIRCLE,   32,   32,   0,   0,  0, 3, 1'b1, 2'd0},
        '{gsf_pkg::REQ_CIRCLE,   32,   32,   0,   0, 63, 2, 1'b1, 2'd0},
        '{gsf_pkg::REQ_CIRCLE,  127, -128,   0,   0, 63, 3, 1'b1, 2'd0},
        '{gsf_pkg::REQ_CIRCLE,   10,   10,   0,   0,  5, 1, 1'b1, 2'd0},
        '{gsf_pkg::REQ_READ,      4,   10,   0,   0,  0, 0, 1'b0, 2'd0},
        '{gsf_pkg::REQ_READ,     10,   10,   0,   0,  0, 0, 1'b0, 2'd0}
    };

    grid_shape_fill u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_x_size     (i_x_size),
        .i_y_size     (i_y_size),
        .i_radius     (i_radius),
        .i_cell_type  (i_cell_type),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Write one cell of the model; drop it when it lies off the grid
    function automatic void paint_cell(int px, int py, logic [gsf_pkg::TYPE_W-1:0] t);
        if (px >= 0 && py >= 0 && px < gsf_pkg::GRID_ROWS && py < gsf_pkg::GRID_COLS) begin
            occ_map[px][py] = t;
        end
    endfunction

    // Apply one command word to the model grid and return its read value
    function automatic logic [gsf_pkg::TYPE_W-1:0] apply_to_grid(t_grid_word w);
        int cx, cy, wx, wy, rr, ix, iy, d, n, s, hw;
        logic [gsf_pkg::TYPE_W-1:0] rv;
        cx = int'($signed(w.x));
        cy = int'($signed(w.y));
        wx = int'(w.xs);
        wy = int'(w.ys);
        rr = int'(w.rad);
        rv = '0;
        case (w.op)
            gsf_pkg::REQ_POINT: begin
                paint_cell(cx, cy, w.ctype);
            end
            gsf_pkg::REQ_RECT: begin
                for (ix = cx; ix < cx + wx; ix++) begin
                    for (iy = cy; iy < cy + wy; iy++) begin
                        paint_cell(ix, iy, w.ctype);
                    end
                end
            end
            gsf_pkg::REQ_CIRCLE: begin
                // Per row offset: half-width is the rounded root of r*r - d*d,
                // span fills just above and just below the center row
                for (d = 0; d < rr; d++) begin
                    n = rr * rr - d * d;
                    s = 0;
                    while ((s + 1) * (s + 1) <= n) s++;
                    hw = (n > s * s + s) ? s + 1 : s;
                    for (ix = cx - hw; ix < cx + hw; ix++) begin
                        paint_cell(ix, cy + d, w.ctype);
                        paint_cell(ix, cy - d - 1, w.ctype);
                    end
                end
            end
            default: begin
                if (cx >= 0 && cy >= 0 && cx < gsf_pkg::GRID_ROWS &&
                    cy < gsf_pkg::GRID_COLS) begin
                    rv = occ_map[cx][cy];
                end
            end
        endcase
        return rv;
    endfunction

    // Random word: reads dominate so the grid is probed often; coordinates
    // mostly near the grid, sizes mostly small, a few at full range
    function automatic t_grid_word pick_word();
        t_grid_word w;
        int sel;
        w = '0;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            w.op = gsf_pkg::REQ_READ;
        end else if (sel < 60) begin
            w.op = gsf_pkg::REQ_POINT;
        end else if (sel < 80) begin
            w.op = gsf_pkg::REQ_RECT;
        end else begin
            w.op = gsf_pkg::REQ_CIRCLE;
        end
        if ($urandom_range(0, 99) < 85) begin
            w.x = gsf_pkg::POS_W'($urandom_range(0, gsf_pkg::GRID_ROWS + 15) - 8);
            w.y = gsf_pkg::POS_W'($urandom_range(0, gsf_pkg::GRID_COLS + 15) - 8);
        end else begin
            w.x = gsf_pkg::POS_W'($urandom);
            w.y = gsf_pkg::POS_W'($urandom);
        end
        if ($urandom_range(0, 99) < 5) begin
            w.xs  = gsf_pkg::SIZE_W'($urandom);
            w.ys  = gsf_pkg::SIZE_W'($urandom);
            w.rad = gsf_pkg::RAD_W'($urandom);
        end else begin
            w.xs  = gsf_pkg::SIZE_W'($urandom_range(0, 15));
            w.ys  = gsf_pkg::SIZE_W'($urandom_range(0, 15));
            w.rad = gsf_pkg::RAD_W'($urandom_range(0, 12));
        end
        w.ctype = gsf_pkg::TYPE_W'($urandom);
        return w;
    endfunction

    // Present one word from a falling edge, hold it until accepted, then
    // record the read value it owes; return at the next falling edge
    task automatic drive_word(input t_grid_word w);
        logic [gsf_pkg::TYPE_W-1:0] rv;
        i_valid     <= 1'b1;
        i_req_type  <= w.op;
        i_x_pos     <= w.x;
        i_y_pos     <= w.y;
        i_x_size    <= w.xs;
        i_y_size    <= w.ys;
        i_radius    <= w.rad;
        i_cell_type <= w.ctype;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        rv = apply_to_grid(w);
        read_value_q.push_back(w.fixed ? w.fixed_val : rv);
        @(negedge i_clk);
    endtask

    // Sender: reset, directed table, then random bursts, then drain
    initial begin
        int k, burst, gap;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req_type  = '0;
        i_x_pos     = '0;
        i_y_pos     = '0;
        i_x_size    = '0;
        i_y_size    = '0;
        i_radius    = '0;
        i_cell_type = '0;
        foreach (occ_map[ix, iy]) occ_map[ix][iy] = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words go back to back; the block clears its grid first,
        // so the first one just waits on o_ready
        for (k = 0; k < N_DIRECT; k++) drive_word(dir_tab[k]);

        // Random words in bursts; some gaps are zero so long unbroken
        // stretches of valid occur too
        k = 0;
        while (k < N_RANDOM) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                drive_word(pick_word());
                k++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;

        // Wait for every owed result, then watch for strays a while
        while (read_value_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
        if (bad_words == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver: stall pattern changes at random intervals (always ready,
    // coin flip, mostly stalled, toggling); once, hold off long enough for
    // the output register and the command side to back up
    initial begin
        int mode, span;
        bit held;
        mode = 0;
        span = 0;
        held = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && words_out >= HOLD_AT) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 96);
            end
            span--;
            case (mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= ~i_ready;
            endcase
        end
    end

    // Check each result word against the oldest owed read value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            words_out <= words_out + 1;
            if (read_value_q.size() == 0) begin
                bad_words++;
                $display("%0t: result word with none owed: read_value exp none act %0d",
                         $time, o_read_value);
            end else begin
                logic [gsf_pkg::TYPE_W-1:0] want;
                want = read_value_q.pop_front();
                if (o_read_value !== want) begin
                    bad_words++;
                    $display("%0t: read_value mismatch exp %0d act %0d",
                             $time, want, o_read_value);
                end
            end
        end
    end

    // Give up well past the slowest expected run
    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
